// ===== rtl/jbaf_pkg.sv =====
`default_nettype none
package jbaf_pkg;

	localparam int RAW_W      = 12;
	localparam int STICK_W    = 13;
	localparam int MV_W       = 14;
	localparam int PCT_W      = 7;
	localparam int BF_W       = 20;
	localparam int CENTER_W   = 12;
	localparam int TRIM_W     = 8;
	localparam int ALPHA_W    = 10;
	localparam int SCALE_W    = 18;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 18;

	localparam int DEF_STICK_CH = 4;
	localparam int RIGHT_X_CH   = 2;
	localparam int RIGHT_Y_CH   = 3;

	localparam logic [CENTER_W-1:0]      CENTER_RST = 12'd2048;
	localparam logic signed [TRIM_W-1:0] TRIM_RST   = 8'sd35;
	localparam logic [ALPHA_W-1:0]       ALPHA_RST  = 10'd922;
	localparam logic [SCALE_W-1:0]       SCALE_RST  = 18'd158440;

	localparam int STICK_MAX = 4095;
	localparam int STICK_MIN = -4096;
	localparam int PCT_MAX   = 100;

	// Shared shift-add multiplier and interpolation divider sizes.
	localparam int MUL_AW = 22;
	localparam int MUL_BW = 12;
	localparam int DIV_NW = 21;
	localparam int DIV_DW = MV_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CENTER = 8'd0,
		REG_TRIM   = 8'd1,
		REG_ALPHA  = 8'd2,
		REG_SCALE  = 8'd3
	} cfg_reg_t;

	localparam int TABLE_ENTRIES = 11;
	localparam int SEG_W = $clog2(TABLE_ENTRIES);

	localparam logic [MV_W-1:0] TBL_MV [TABLE_ENTRIES] = '{
		14'd8400, 14'd8100, 14'd7900, 14'd7740, 14'd7600, 14'd7500,
		14'd7400, 14'd7300, 14'd7140, 14'd6800, 14'd6000
	};
	localparam logic [PCT_W-1:0] TBL_PCT [TABLE_ENTRIES] = '{
		7'd100, 7'd90, 7'd80, 7'd70, 7'd60, 7'd50, 7'd40, 7'd30, 7'd20, 7'd10, 7'd0
	};

	function automatic int in_data_w(int ch);
		return (((ch + 1) * RAW_W + 7) / 8) * 8;
	endfunction

	function automatic int out_data_w(int ch);
		return ((ch * STICK_W + MV_W + PCT_W + 7) / 8) * 8;
	endfunction

endpackage
`default_nettype wire

// ===== rtl/jbaf_mul.sv =====
`default_nettype none
module jbaf_mul #(
	parameter int AW = jbaf_pkg::MUL_AW,
	parameter int BW = jbaf_pkg::MUL_BW
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 start,
	input  wire logic signed [AW-1:0] a,
	input  wire logic [BW-1:0]        b,
	output logic                      done,
	output logic signed [AW+BW-1:0]   p
);
	localparam int CNT_W = $clog2(BW + 1);

	logic signed [AW-1:0] a_q;
	logic signed [AW+1:0] hi_q;
	logic [BW-1:0]        lo_q;
	logic [CNT_W-1:0]     cnt_q;
	logic                 busy_q;
	logic                 done_q;
	logic signed [AW+1:0] sum;

	// One multiplier bit per cycle, LSB first; the partial sum shifts right into lo_q.
	assign sum = hi_q + (lo_q[0] ? (AW+2)'(a_q) : '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(BW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			a_q  <= a;
			hi_q <= '0;
			lo_q <= b;
		end else if (busy_q) begin
			hi_q <= sum >>> 1;
			lo_q <= {sum[0], lo_q[BW-1:1]};
		end
	end

	assign done = done_q;
	assign p    = $signed({hi_q[AW-1:0], lo_q});
endmodule
`default_nettype wire

// ===== rtl/jbaf_div.sv =====
`default_nettype none
module jbaf_div #(
	parameter int NW = jbaf_pkg::DIV_NW,
	parameter int DW = jbaf_pkg::DIV_DW,
	parameter int QW = jbaf_pkg::PCT_W
) (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          start,
	input  wire logic [NW-1:0] num,
	input  wire logic [DW-1:0] den,
	output logic               done,
	output logic [QW-1:0]      quo
);
	localparam int CW    = (NW > DW + QW - 1) ? NW : DW + QW - 1;
	localparam int CNT_W = $clog2(QW + 1);

	logic [CW-1:0]    rem_q;
	logic [CW-1:0]    d_q;
	logic [QW-1:0]    q_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic             done_q;
	logic             fits;

	// Restoring division, one quotient bit per cycle, MSB first.
	assign fits = (rem_q >= d_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= CNT_W'(QW);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CNT_W'(1);
			if (cnt_q == CNT_W'(1)) begin
				busy_q <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= CW'(num);
			d_q   <= CW'({den, {(QW-1){1'b0}}});
			q_q   <= '0;
		end else if (busy_q) begin
			if (fits) begin
				rem_q <= rem_q - d_q;
			end
			q_q <= {q_q[QW-2:0], fits};
			d_q <= d_q >> 1;
		end
	end

	assign done = done_q;
	assign quo  = q_q;
endmodule
`default_nettype wire

// ===== rtl/joystick_battery_adc_filter_unit.sv =====
// Each scan filters the stick channels in turn, then scales and filters the battery, then
// looks up the charge percent and loads the output register; no division is needed when
// the voltage lies outside the table. A new scan is accepted only in the idle state, and
// the unit stays busy longer while a result waits on m_tready; all products share one
// bit-serial multiplier. One more scan is taken while a finished result waits. Reset
// (arst_n low, asynchronous) restores defaults, zeroes filters.
`default_nettype none
module joystick_battery_adc_filter_unit #(
	parameter int STICK_CHANNELS = jbaf_pkg::DEF_STICK_CH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic s_tvalid,
	output logic      s_tready,
	// Fields from bit 0: stick raw samples (12 bits each), battery_raw (12), zero pad.
	input  wire logic [jbaf_pkg::in_data_w(STICK_CHANNELS)-1:0] s_tdata,
	output logic      m_tvalid,
	input  wire logic m_tready,
	// Fields from bit 0: stick outputs (13 bits each), battery_mv (14),
	// charge percent (7), zero pad.
	output logic [jbaf_pkg::out_data_w(STICK_CHANNELS)-1:0] m_tdata,
	input  wire logic cfg_valid,
	output logic      cfg_ready,
	input  wire logic [jbaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [jbaf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import jbaf_pkg::*;

	localparam int CH_W  = (STICK_CHANNELS > 1) ? $clog2(STICK_CHANNELS) : 1;
	localparam int PW    = MUL_AW + MUL_BW;

	typedef enum logic [7:0] {
		ST_IDLE = 8'b0000_0001,
		ST_STK  = 8'b0000_0010,
		ST_BSCL = 8'b0000_0100,
		ST_BFLT = 8'b0000_1000,
		ST_PSEL = 8'b0001_0000,
		ST_PMUL = 8'b0010_0000,
		ST_PDIV = 8'b0100_0000,
		ST_DONE = 8'b1000_0000
	} state_t;

	state_t state_q;

	logic [CENTER_W-1:0]      center_q;
	logic signed [TRIM_W-1:0] trim_q;
	logic [ALPHA_W-1:0]       alpha_q;
	logic [SCALE_W-1:0]       scale_q;

	logic [RAW_W-1:0]          raw_q [STICK_CHANNELS];
	logic [RAW_W-1:0]          bat_raw_q;
	logic signed [STICK_W-1:0] stick_q [STICK_CHANNELS];
	logic [BF_W-1:0]           bf_q;
	logic [BF_W-1:0]           bnew_q;
	logic [CH_W-1:0]           ch_q;
	logic [SEG_W-1:0]          seg_q;
	logic [PCT_W-1:0]          pct_q;
	logic                      issue_q;

	logic signed [STICK_W-1:0] out_stick_q [STICK_CHANNELS];
	logic [MV_W-1:0]           out_mv_q;
	logic [PCT_W-1:0]          out_pct_q;
	logic                      out_valid_q;

	logic signed [MUL_AW-1:0] mul_a;
	logic [MUL_BW-1:0]        mul_b;
	logic                     mul_done;
	logic signed [PW-1:0]     prod;
	logic                     div_start;
	logic                     div_done;
	logic [PCT_W-1:0]         quo;

	logic signed [14:0]       v;
	logic signed [14:0]       diff;
	logic signed [PW-1:0]     acc_s;
	logic signed [PW-1:0]     qs;
	logic signed [STICK_W-1:0] stick_new;
	logic signed [PW-1:0]     acc_b;
	logic signed [PW-1:0]     qb;
	logic [BF_W-1:0]          bf_new;
	logic [MV_W-1:0]          mv;
	logic [SEG_W-1:0]         seg;
	logic [SEG_W-1:0]         seg_lo;
	logic [MV_W-1:0]          dv;
	logic [PCT_W-1:0]         dp;
	logic                     out_load;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign m_tvalid  = out_valid_q;
	assign out_load  = (state_q == ST_DONE) && (!out_valid_q || m_tready);

	// Centered, trimmed and sign-corrected sample of the current stick channel.
	always_comb begin
		v = $signed({3'b0, raw_q[ch_q]}) - $signed({3'b0, center_q});
		if (int'(ch_q) == RIGHT_Y_CH) begin
			v = v - 15'(trim_q);
		end
		if (int'(ch_q) == RIGHT_X_CH || int'(ch_q) == RIGHT_Y_CH) begin
			v = -v;
		end
		diff = 15'(stick_q[ch_q]) - v;
	end

	// The filter is rewritten as new*1024 + (old - new)*alpha, so one product suffices.
	always_comb begin
		acc_s = (PW'(v) <<< 10) + prod;
		if (acc_s < 0) begin
			qs = (acc_s + PW'(1023)) >>> 10;
		end else begin
			qs = acc_s >>> 10;
		end
		if (qs > PW'(STICK_MAX)) begin
			stick_new = STICK_W'(STICK_MAX);
		end else if (qs < PW'(STICK_MIN)) begin
			stick_new = STICK_W'(STICK_MIN);
		end else begin
			stick_new = qs[STICK_W-1:0];
		end
	end

	always_comb begin
		acc_b = $signed(PW'({bnew_q, 10'b0})) + prod;
		qb    = acc_b >>> 10;
		if (qb > $signed(PW'({BF_W{1'b1}}))) begin
			bf_new = '1;
		end else if (qb < 0) begin
			bf_new = '0;
		end else begin
			bf_new = qb[BF_W-1:0];
		end
	end

	// Table entries descend, so the first segment whose lower end is at or below
	// the voltage is the one that contains it.
	always_comb begin
		mv  = bf_q[BF_W-1 -: MV_W];
		seg = SEG_W'(TABLE_ENTRIES - 2);
		for (int i = TABLE_ENTRIES - 2; i >= 0; i--) begin
			if (mv >= TBL_MV[i+1]) begin
				seg = SEG_W'(i);
			end
		end
		seg_lo = seg_q + SEG_W'(1);
		dv     = TBL_MV[seg_q] - TBL_MV[seg_lo];
		dp     = TBL_PCT[seg_q] - TBL_PCT[seg_lo];
	end

	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (state_q)
			ST_STK: begin
				mul_a = MUL_AW'(diff);
				mul_b = MUL_BW'(alpha_q);
			end
			ST_BSCL: begin
				mul_a = $signed(MUL_AW'(scale_q));
				mul_b = MUL_BW'(bat_raw_q);
			end
			ST_BFLT: begin
				mul_a = MUL_AW'($signed({1'b0, bf_q}) - $signed({1'b0, bnew_q}));
				mul_b = MUL_BW'(alpha_q);
			end
			ST_PMUL: begin
				mul_a = $signed(MUL_AW'(mv - TBL_MV[seg_lo]));
				mul_b = MUL_BW'(dp);
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	assign div_start = (state_q == ST_PMUL) && mul_done && (dv != '0);

	jbaf_mul #(.AW(MUL_AW), .BW(MUL_BW)) u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (issue_q),
		.a      (mul_a),
		.b      (mul_b),
		.done   (mul_done),
		.p      (prod)
	);

	jbaf_div #(.NW(DIV_NW), .DW(DIV_DW), .QW(PCT_W)) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (prod[DIV_NW-1:0]),
		.den    (dv),
		.done   (div_done),
		.quo    (quo)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_q <= CENTER_RST;
			trim_q   <= TRIM_RST;
			alpha_q  <= ALPHA_RST;
			scale_q  <= SCALE_RST;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_CENTER: center_q <= cfg_data[CENTER_W-1:0];
				REG_TRIM:   trim_q   <= $signed(cfg_data[TRIM_W-1:0]);
				REG_ALPHA:  alpha_q  <= cfg_data[ALPHA_W-1:0];
				REG_SCALE:  scale_q  <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			issue_q     <= 1'b0;
			ch_q        <= '0;
			out_valid_q <= 1'b0;
			bf_q        <= '0;
			for (int c = 0; c < STICK_CHANNELS; c++) begin
				stick_q[c] <= '0;
			end
		end else begin
			issue_q <= 1'b0;
			if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						ch_q    <= '0;
						issue_q <= 1'b1;
						state_q <= ST_STK;
					end
				end
				ST_STK: begin
					if (mul_done) begin
						stick_q[ch_q] <= stick_new;
						issue_q       <= 1'b1;
						if (int'(ch_q) == STICK_CHANNELS - 1) begin
							state_q <= ST_BSCL;
						end else begin
							ch_q <= ch_q + CH_W'(1);
						end
					end
				end
				ST_BSCL: begin
					if (mul_done) begin
						issue_q <= 1'b1;
						state_q <= ST_BFLT;
					end
				end
				ST_BFLT: begin
					if (mul_done) begin
						bf_q    <= bf_new;
						state_q <= ST_PSEL;
					end
				end
				ST_PSEL: begin
					if (mv >= TBL_MV[0] || mv <= TBL_MV[TABLE_ENTRIES-1]) begin
						state_q <= ST_DONE;
					end else begin
						issue_q <= 1'b1;
						state_q <= ST_PMUL;
					end
				end
				ST_PMUL: begin
					if (mul_done) begin
						state_q <= (dv == '0) ? ST_DONE : ST_PDIV;
					end
				end
				ST_PDIV: begin
					if (div_done) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_load) begin
						out_valid_q <= 1'b1;
						state_q     <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && s_tvalid) begin
			for (int c = 0; c < STICK_CHANNELS; c++) begin
				raw_q[c] <= s_tdata[c*RAW_W +: RAW_W];
			end
			bat_raw_q <= s_tdata[STICK_CHANNELS*RAW_W +: RAW_W];
		end
		if (state_q == ST_BSCL && mul_done) begin
			bnew_q <= prod[10 +: BF_W];
		end
		if (state_q == ST_PSEL) begin
			seg_q <= seg;
			if (mv >= TBL_MV[0]) begin
				pct_q <= PCT_W'(PCT_MAX);
			end else begin
				pct_q <= '0;
			end
		end
		if (state_q == ST_PMUL && mul_done) begin
			pct_q <= TBL_PCT[seg_lo];
		end
		if (state_q == ST_PDIV && div_done) begin
			pct_q <= TBL_PCT[seg_lo] + quo;
		end
		if (out_load) begin
			for (int c = 0; c < STICK_CHANNELS; c++) begin
				out_stick_q[c] <= stick_q[c];
			end
			out_mv_q  <= mv;
			out_pct_q <= pct_q;
		end
	end

	always_comb begin
		m_tdata = '0;
		for (int c = 0; c < STICK_CHANNELS; c++) begin
			m_tdata[c*STICK_W +: STICK_W] = out_stick_q[c];
		end
		m_tdata[STICK_CHANNELS*STICK_W +: MV_W]         = out_mv_q;
		m_tdata[STICK_CHANNELS*STICK_W + MV_W +: PCT_W] = out_pct_q;
	end
endmodule
`default_nettype wire

// ===== rtl/jbaf_chk.sv =====
`default_nettype none
module jbaf_chk #(
	parameter int CH = jbaf_pkg::DEF_STICK_CH
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic s_tvalid,
	input wire logic s_tready,
	input wire logic [jbaf_pkg::in_data_w(CH)-1:0] s_tdata,
	input wire logic m_tvalid,
	input wire logic m_tready,
	input wire logic [jbaf_pkg::out_data_w(CH)-1:0] m_tdata,
	input wire logic cfg_valid,
	input wire logic cfg_ready,
	input wire logic [jbaf_pkg::CFG_IDX_W-1:0]  cfg_index,
	input wire logic [jbaf_pkg::CFG_DATA_W-1:0] cfg_data
);
	import jbaf_pkg::*;

	localparam int MV_LSB  = CH * STICK_W;
	localparam int PCT_LSB = MV_LSB + MV_W;

	logic [MV_W-1:0]  mv;
	logic [PCT_W-1:0] pct;

	assign mv  = m_tdata[MV_LSB +: MV_W];
	assign pct = m_tdata[PCT_LSB +: PCT_W];

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while a scan is in progress");

	a_pct_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> pct <= PCT_W'(PCT_MAX))
		else $error("battery percent above full scale");

	a_pct_full: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && mv >= TBL_MV[0] |-> pct == PCT_W'(PCT_MAX))
		else $error("battery above top of table but not reported full");
endmodule

bind joystick_battery_adc_filter_unit jbaf_chk #(.CH(STICK_CHANNELS)) u_jbaf_chk (.*);
`default_nettype wire

// ===== dv/joystick_battery_adc_filter_unit_test.sv =====
`default_nettype none
module joystick_battery_adc_filter_unit_test;
	import jbaf_pkg::*;

	localparam int CH    = DEF_STICK_CH;
	localparam int IN_W  = in_data_w(CH);
	localparam int OUT_W = out_data_w(CH);
	localparam int IDLE_LIMIT = 20000;

	typedef struct {
		logic signed [STICK_W-1:0] stick [CH];
		logic [MV_W-1:0]           mv;
		logic [PCT_W-1:0]          pct;
	} scan_result_t;

	// Tracks filter state and registers, and the queue of pending scan results.
	class filter_scoreboard;
		logic [CENTER_W-1:0]       center;
		logic signed [TRIM_W-1:0]  trim;
		logic [ALPHA_W-1:0]        alpha;
		logic [SCALE_W-1:0]        scale;
		logic signed [STICK_W-1:0] stick_state [CH];
		logic [BF_W-1:0]           batt_state;
		scan_result_t              pending [$];
		int                        errors;

		function void clear();
			center = CENTER_RST;
			trim = TRIM_RST;
			alpha = ALPHA_RST;
			scale = SCALE_RST;
			foreach (stick_state[i]) stick_state[i] = '0;
			batt_state = '0;
			pending.delete();
			errors = 0;
		endfunction

		function void write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
			case (idx)
				REG_CENTER: center = d[CENTER_W-1:0];
				REG_TRIM:   trim = d[TRIM_W-1:0];
				REG_ALPHA:  alpha = d[ALPHA_W-1:0];
				REG_SCALE:  scale = d[SCALE_W-1:0];
				default: ;
			endcase
		endfunction

		function string stick_name(int i);
			case (i)
				0: return "left_x";
				1: return "left_y";
				2: return "right_x";
				default: return "right_y";
			endcase
		endfunction

		function logic [PCT_W-1:0] charge_percent(int mv);
			int vh, vl, ph, pl;
			if (mv >= TBL_MV[0]) return PCT_W'(PCT_MAX);
			if (mv <= TBL_MV[TABLE_ENTRIES-1]) return '0;
			for (int i = 0; i < TABLE_ENTRIES - 1; i++) begin
				vh = TBL_MV[i];
				vl = TBL_MV[i+1];
				if (mv >= vl && mv <= vh) begin
					ph = TBL_PCT[i];
					pl = TBL_PCT[i+1];
					if (vh == vl) return PCT_W'(pl);
					return PCT_W'(pl + ((mv - vl) * (ph - pl)) / (vh - vl));
				end
			end
			return '0;
		endfunction

		function void note_scan(logic [IN_W-1:0] d);
			scan_result_t r;
			longint v, acc, q;
			longint unsigned bnew, bacc;
			for (int i = 0; i < CH; i++) begin
				v = longint'(d[i*RAW_W +: RAW_W]) - longint'(center);
				if (i == RIGHT_Y_CH) v -= trim;
				if (i == RIGHT_X_CH || i == RIGHT_Y_CH) v = -v;
				acc = longint'(stick_state[i]) * alpha + v * (1024 - longint'(alpha));
				q = acc / 1024;
				if (q > STICK_MAX) q = STICK_MAX;
				if (q < STICK_MIN) q = STICK_MIN;
				stick_state[i] = STICK_W'(q);
				r.stick[i] = STICK_W'(q);
			end
			bnew = (longint'(d[CH*RAW_W +: RAW_W]) * scale) >> 10;
			bacc = longint'(batt_state) * alpha + bnew * (1024 - longint'(alpha));
			bacc = bacc >> 10;
			if (bacc > 64'hFFFFF) bacc = 64'hFFFFF;
			batt_state = BF_W'(bacc);
			r.mv = batt_state[BF_W-1 -: MV_W];
			r.pct = charge_percent(int'(batt_state >> 6));
			pending.push_back(r);
		endfunction

		function void check_result(logic [OUT_W-1:0] d);
			scan_result_t e;
			logic signed [STICK_W-1:0] s;
			logic [MV_W-1:0] mv;
			logic [PCT_W-1:0] pct;
			if (pending.size() == 0) begin
				$error("unexpected result %h", d);
				errors++;
				return;
			end
			e = pending.pop_front();
			for (int i = 0; i < CH; i++) begin
				s = d[i*STICK_W +: STICK_W];
				if (s !== e.stick[i]) begin
					$error("%s: expected %0d, got %0d", stick_name(i), e.stick[i], s);
					errors++;
				end
			end
			mv = d[CH*STICK_W +: MV_W];
			pct = d[CH*STICK_W + MV_W +: PCT_W];
			if (mv !== e.mv) begin
				$error("battery_mv: expected %0d, got %0d", e.mv, mv);
				errors++;
			end
			if (pct !== e.pct) begin
				$error("charge percent: expected %0d, got %0d", e.pct, pct);
				errors++;
			end
		endfunction
	endclass

	logic clk = 0;
	logic arst_n = 0;
	logic s_tvalid = 0;
	logic s_tready;
	logic [IN_W-1:0] s_tdata = '0;
	logic m_tvalid;
	logic m_tready = 0;
	logic [OUT_W-1:0] m_tdata;
	logic cfg_valid = 0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	filter_scoreboard board = new();
	bit hold_sink = 0;
	int idle_cycles = 0;

	joystick_battery_adc_filter_unit uut (.*);

	always #5 clk = ~clk;

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (r < 50) return 0;
		if (r < 92) return $urandom_range(1, 4);
		return $urandom_range(10, 60);
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) board.check_result(m_tdata);
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	always @(posedge clk) begin
		if (idle_cycles > IDLE_LIMIT) begin
			$display("joystick_battery_adc_filter_unit verification failed");
			$finish;
		end
	end

	// Result side: random stalls, or a long hold-off on request.
	initial begin
		int g;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_sink) begin
				m_tready <= 0;
			end else begin
				g = pick_gap();
				if (g > 0 && $urandom_range(0, 3) == 0) begin
					m_tready <= 0;
					repeat (g) @(negedge clk);
				end
				m_tready <= 1;
			end
		end
	end

	task automatic send_scan(logic [IN_W-1:0] d, bit gaps);
		int g;
		if (gaps) begin
			g = pick_gap();
			if (g > 0) begin
				s_tvalid <= 0;
				repeat (g) @(negedge clk);
			end
		end
		s_tvalid <= 1;
		s_tdata <= d;
		do @(posedge clk); while (!s_tready);
		board.note_scan(d);
		@(negedge clk);
	endtask

	task automatic end_burst();
		s_tvalid <= 0;
	endtask

	task automatic drain();
		s_tvalid <= 0;
		while (board.pending.size() != 0) @(negedge clk);
		repeat (150) @(negedge clk);
	endtask

	task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_W-1:0] d);
		cfg_valid <= 1;
		cfg_index <= idx;
		cfg_data <= d;
		do @(posedge clk); while (!cfg_ready);
		board.write_reg(idx, d);
		@(negedge clk);
		cfg_valid <= 0;
		@(negedge clk);
	endtask

	function automatic logic [IN_W-1:0] make_scan(int lx, int ly, int rx, int ry, int b);
		logic [IN_W-1:0] d;
		d = '0;
		d[0 +: RAW_W] = RAW_W'(lx);
		d[RAW_W +: RAW_W] = RAW_W'(ly);
		d[2*RAW_W +: RAW_W] = RAW_W'(rx);
		d[3*RAW_W +: RAW_W] = RAW_W'(ry);
		d[4*RAW_W +: RAW_W] = RAW_W'(b);
		return d;
	endfunction

	function automatic logic [IN_W-1:0] rand_scan();
		return make_scan($urandom_range(0, 4095), $urandom_range(0, 4095),
			$urandom_range(0, 4095), $urandom_range(0, 4095), $urandom_range(0, 4095));
	endfunction

	initial begin
		board.clear();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1;
		@(negedge clk);

		// Directed: extremes at reset settings, then instant-tracking filter
		// so the battery sweeps the table.
		send_scan(make_scan(0, 4095, 0, 4095, 0), 0);
		send_scan(make_scan(4095, 0, 4095, 0, 4095), 0);
		send_scan(make_scan(2048, 2048, 2048, 2048, 2048), 0);
		drain();
		write_reg(REG_ALPHA, 0);
		write_reg(REG_CENTER, 4095);
		write_reg(REG_TRIM, 18'h80);
		write_reg(cfg_reg_t'(8'd7), 18'h3FFFF);
		send_scan(make_scan(0, 4095, 0, 0, 4095), 0);
		drain();
		write_reg(REG_SCALE, 18'h3FFFF);
		send_scan(make_scan(0, 0, 4095, 0, 4095), 0);
		drain();
		write_reg(REG_CENTER, 0);
		write_reg(REG_TRIM, 127);
		write_reg(REG_SCALE, 196608);
		// Millivolts equal three times the raw count here; sweep the battery near each table entry.
		foreach (TBL_MV[i]) send_scan(make_scan(4095, 0, 4095, 0, TBL_MV[i] / 3 + i % 2), 1);
		send_scan(make_scan(1, 2, 4, 8, 16), 1);
		send_scan(make_scan(2730, 1365, 2730, 1365, 2730), 1);
		drain();
		write_reg(REG_ALPHA, 1023);
		send_scan(make_scan(0, 4095, 0, 4095, 4095), 1);
		drain();

		// Random phases, each with its own register setting.
		for (int ph = 0; ph < 12; ph++) begin
			case (ph % 4)
				0: write_reg(REG_ALPHA, $urandom_range(0, 1023));
				1: write_reg(REG_CENTER, $urandom_range(0, 4095));
				2: write_reg(REG_TRIM, $urandom_range(0, 255));
				default: write_reg(REG_SCALE, $urandom_range(0, 262143));
			endcase
			if (ph == 0) write_reg(REG_SCALE, 140000 + $urandom_range(0, 40000));
			if (ph == 4) write_reg(REG_ALPHA, $urandom_range(0, 1) ? 0 : 1023);
			for (int n = 0; n < 150; n++) begin
				if (ph == 3 && n == 10) begin
					// Back-pressure: results stop while scans keep coming.
					hold_sink = 1;
					fork
						begin
							repeat (800) @(negedge clk);
							hold_sink = 0;
						end
					join_none
				end
				if (ph == 6 && n == 75) drain();
				if (n % 2 == 0 && ph % 2 == 0)
					send_scan(make_scan(2048 + $urandom_range(0, 200) - 100,
						$urandom_range(1800, 2300), $urandom_range(0, 4095),
						$urandom_range(1900, 2200), $urandom_range(2400, 3600)),
						ph != 5);
				else
					send_scan(rand_scan(), ph != 5);
			end
			drain();
		end
		end_burst();

		if (board.errors == 0 && board.pending.size() == 0)
			$display("joystick_battery_adc_filter_unit verification clean");
		else
			$display("joystick_battery_adc_filter_unit verification failed");
		$finish;
	end
endmodule
`default_nettype wire
